>>> hdl/rcisa_pkg.sv
`timescale 1ns / 1ps
// Shared types, command codes and helpers for the icon slot allocator.
// No dependencies; used by the controller, the datapath and the top level.
package rcisa_pkg;

    localparam int REF_W   = 8;
    localparam int SLOT_W  = 6;
    localparam int ICON_W  = 8;
    localparam int TILE_W  = 10;
    localparam int CMD_W   = 2;
    localparam int ENTRY_W = REF_W + SLOT_W;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 24;

    localparam logic [TILE_W-1:0] TILE_BASE = 10'h300;
    localparam logic [REF_W-1:0]  REF_MAX   = 8'hFF;

    localparam logic [CMD_W-1:0] CMD_GET       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ONE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_COUNT     = 2'd3;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic hit_upd;
        logic free_upd;
        logic clear_all;
        logic scan_init;
        logic alloc_step;
        logic count_step;
        logic res_zero;
        logic res_full;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             in_range;
        logic             has_slot;
        logic             scan_done;
        logic             scan_free;
        logic             out_free;
    } dp_stat_t;

    function automatic logic [REF_W-1:0] ref_inc(input logic [REF_W-1:0] r);
        ref_inc = (r == REF_MAX) ? r : r + 8'd1;
    endfunction

    // 768 - 4 * slot, slot <= 63 so no wrap
    function automatic logic [TILE_W-1:0] tile_of(input logic [SLOT_W-1:0] s);
        tile_of = TILE_BASE - {2'b00, s, 2'b00};
    endfunction

endpackage

>>> hdl/rcisa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcisa_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 224
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/rcisa_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the icon slot allocator.
// Depends on rcisa_pkg; drives the datapath through dp_cmd_t, reads dp_stat_t.
module rcisa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rcisa_pkg::dp_stat_t st,
    output rcisa_pkg::dp_cmd_t  cmd
);
    import rcisa_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_LOOKUP = 3'd2;
    localparam logic [2:0] S_ALLOC  = 3'd3;
    localparam logic [2:0] S_COUNT  = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (st.cmd)
                    CMD_GET:
                    begin
                        if (st.in_range)
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = S_LOOKUP;
                        end
                        else
                        begin
                            cmd.res_full = 1'b1;
                            state_next   = S_RESULT;
                        end
                    end
                    CMD_CLEAR_ONE:
                    begin
                        cmd.res_zero = 1'b1;
                        if (st.in_range)
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = S_LOOKUP;
                        end
                        else
                        begin
                            state_next = S_RESULT;
                        end
                    end
                    CMD_CLEAR_ALL:
                    begin
                        cmd.clear_all = 1'b1;
                        cmd.res_zero  = 1'b1;
                        state_next    = S_RESULT;
                    end
                    CMD_COUNT:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_COUNT;
                    end
                    default:
                    begin
                        cmd.res_zero = 1'b1;
                        state_next   = S_RESULT;
                    end
                endcase
            end
            S_LOOKUP:
            begin
                state_next = S_RESULT;
                if (st.cmd == CMD_GET)
                begin
                    if (st.has_slot)
                    begin
                        cmd.hit_upd = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_ALLOC;
                    end
                end
                else if (st.cmd == CMD_CLEAR_ONE && st.has_slot)
                begin
                    cmd.free_upd = 1'b1;
                end
            end
            S_ALLOC:
            begin
                cmd.alloc_step = 1'b1;
                if (st.scan_done || st.scan_free)
                begin
                    state_next = S_RESULT;
                end
            end
            S_COUNT:
            begin
                cmd.count_step = 1'b1;
                if (st.scan_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/rcisa_dp.sv
`timescale 1ns / 1ps
// Datapath: per-icon table RAM with valid bits, slot occupancy, scan counter,
// result and output registers. Depends on rcisa_pkg and rcisa_ram.
module rcisa_dp #(
    parameter int ICON_COUNT = 224,
    parameter int SLOT_COUNT = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [rcisa_pkg::IN_W-1:0]      s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rcisa_pkg::OUT_W-1:0]     m_tdata,
    input  rcisa_pkg::dp_cmd_t              cmd,
    output rcisa_pkg::dp_stat_t             st
);
    import rcisa_pkg::*;

    localparam int IDX_W = (ICON_COUNT > 1) ? $clog2(ICON_COUNT) : 1;
    localparam int SIW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [CMD_W-1:0]      cmd_reg;
    logic [ICON_W-1:0]     icon_reg;
    logic [IDX_W-1:0]      idx;
    logic [ICON_COUNT-1:0] icon_valid_reg;
    logic [SLOT_COUNT-1:0] slot_valid_reg;
    logic [SLOT_W-1:0]     scan_reg;
    logic [SLOT_W-1:0]     count_reg;
    logic [REF_W-1:0]      ref_reg;

    logic                  ram_we;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [REF_W-1:0]      ent_ref;
    logic [SLOT_W-1:0]     ent_slot;
    logic [SLOT_W-1:0]     free_slot;
    logic [SLOT_W-1:0]     scan_plus;
    logic                  scan_done;
    logic                  scan_free;

    logic [TILE_W-1:0]     res_tile_reg;
    logic                  res_load_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic                  res_status_reg;
    logic [SLOT_W-1:0]     res_count_reg;

    logic                  m_tvalid_reg;
    logic [TILE_W-1:0]     m_tile_reg;
    logic                  m_load_reg;
    logic [SLOT_W-1:0]     m_slot_reg;
    logic                  m_status_reg;
    logic [SLOT_W-1:0]     m_count_reg;

    assign idx       = icon_reg[IDX_W-1:0];
    assign ent_ref   = icon_valid_reg[idx] ? ram_rdata[ENTRY_W-1:SLOT_W] : '0;
    assign ent_slot  = icon_valid_reg[idx] ? ram_rdata[SLOT_W-1:0] : '0;
    assign free_slot = ent_slot - 6'd1;
    assign scan_plus = scan_reg + 6'd1;
    assign scan_done = (scan_reg == SLOT_W'(SLOT_COUNT));
    assign scan_free = !slot_valid_reg[scan_reg[SIW-1:0]];

    assign st.cmd       = cmd_reg;
    assign st.in_range  = ({1'b0, icon_reg} < 9'(ICON_COUNT));
    assign st.has_slot  = (ent_slot != '0);
    assign st.scan_done = scan_done;
    assign st.scan_free = scan_free;
    assign st.out_free  = !m_tvalid_reg || m_tready;

    rcisa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ICON_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = {ent_ref, ent_slot};
        if (cmd.hit_upd)
        begin
            ram_we    = 1'b1;
            ram_wdata = {ref_inc(ent_ref), ent_slot};
        end
        else if (cmd.free_upd)
        begin
            ram_we    = 1'b1;
            ram_wdata = {ent_ref, {SLOT_W{1'b0}}};
        end
        else if (cmd.alloc_step)
        begin
            if (scan_done)
            begin
                ram_we    = 1'b1;
                ram_wdata = {ref_inc(ref_reg), {SLOT_W{1'b0}}};
            end
            else if (scan_free)
            begin
                ram_we    = 1'b1;
                ram_wdata = {ref_inc(ref_reg), scan_plus};
            end
        end
    end

    // occupancy and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icon_valid_reg <= '0;
            slot_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear_all)
            begin
                icon_valid_reg <= '0;
                slot_valid_reg <= '0;
            end
            else
            begin
                if (ram_we)
                begin
                    icon_valid_reg[idx] <= 1'b1;
                end
                if (cmd.free_upd)
                begin
                    slot_valid_reg[free_slot[SIW-1:0]] <= 1'b0;
                end
                if (cmd.alloc_step && !scan_done && scan_free)
                begin
                    slot_valid_reg[scan_reg[SIW-1:0]] <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg  <= s_tdata[CMD_W-1:0];
            icon_reg <= s_tdata[CMD_W+ICON_W-1:CMD_W];
        end
        if (cmd.scan_init)
        begin
            scan_reg  <= '0;
            count_reg <= '0;
            ref_reg   <= ent_ref;
        end
        else if (cmd.alloc_step && !scan_done && !scan_free)
        begin
            scan_reg <= scan_plus;
        end
        else if (cmd.count_step && !scan_done)
        begin
            scan_reg  <= scan_plus;
            count_reg <= count_reg + {{(SLOT_W-1){1'b0}}, ~scan_free};
        end

        if (cmd.res_zero || (cmd.count_step && scan_done))
        begin
            res_tile_reg   <= '0;
            res_load_reg   <= 1'b0;
            res_slot_reg   <= '0;
            res_status_reg <= 1'b0;
            res_count_reg  <= cmd.count_step ? count_reg : '0;
        end
        else if (cmd.res_full || (cmd.alloc_step && scan_done))
        begin
            res_tile_reg   <= TILE_BASE;
            res_load_reg   <= 1'b0;
            res_slot_reg   <= '0;
            res_status_reg <= 1'b1;
            res_count_reg  <= '0;
        end
        else if (cmd.hit_upd)
        begin
            res_tile_reg   <= tile_of(ent_slot);
            res_load_reg   <= 1'b0;
            res_slot_reg   <= ent_slot;
            res_status_reg <= 1'b0;
            res_count_reg  <= '0;
        end
        else if (cmd.alloc_step && scan_free)
        begin
            res_tile_reg   <= tile_of(scan_plus);
            res_load_reg   <= 1'b1;
            res_slot_reg   <= scan_plus;
            res_status_reg <= 1'b0;
            res_count_reg  <= '0;
        end

        if (cmd.out_load)
        begin
            m_tile_reg   <= res_tile_reg;
            m_load_reg   <= res_load_reg;
            m_slot_reg   <= res_slot_reg;
            m_status_reg <= res_status_reg;
            m_count_reg  <= res_count_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_count_reg, m_status_reg, m_slot_reg, m_load_reg, m_tile_reg};

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_count_reg <= SLOT_W'(SLOT_COUNT)))
        else $error("active count above slot count");

    a_load_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_load_reg) |-> (m_slot_reg != '0 && !m_status_reg))
        else $error("load flagged without an assigned slot");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_status_reg) |-> (m_slot_reg == '0 && m_tile_reg == TILE_BASE))
        else $error("full status with a slot or wrong tile");

    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_all |=> (slot_valid_reg == '0 && icon_valid_reg == '0))
        else $error("tables not empty after clear-all");
`endif

endmodule

>>> hdl/refcounted_icon_slot_allocator.sv
`timescale 1ns / 1ps
// One transaction in, one transaction out. Hit, clear and clear-all go from accept
// through decode (and a table lookup for hit and clear) to the result; a new allocation
// or a count walks the slot occupancy bits one per cycle, up to SLOT_COUNT of them.
// One request in flight at a time; a finished result waits in the output register.
// rst_n (async, active low) empties every table at once via per-icon valid bits.
module refcounted_icon_slot_allocator #(
    parameter int ICON_COUNT = 224,
    parameter int SLOT_COUNT = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rcisa_pkg::IN_W-1:0]  s_tdata,  // cmd[1:0], icon_index[9:2], zero pad
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rcisa_pkg::OUT_W-1:0] m_tdata   // tile_address[9:0], load_needed[10],
                                                  // slot_number[16:11], status[17],
                                                  // active_count[23:18]
);
    import rcisa_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    rcisa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (dp_stat),
        .cmd      (dp_cmd)
    );

    rcisa_dp #(
        .ICON_COUNT (ICON_COUNT),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (dp_cmd),
        .st       (dp_stat)
    );

endmodule

>>> test/refcounted_icon_slot_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_icon_slot_allocator: directed and random
// get/clear/count streams checked against an in-bench slot allocation model.
// Depends on rcisa_pkg and the refcounted_icon_slot_allocator RTL only.
module refcounted_icon_slot_allocator_tb;

    import rcisa_pkg::*;

    localparam int ICON_N      = 224;
    localparam int SLOT_N      = 32;
    localparam int RAND_ITEMS  = 1550;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        logic [TILE_W-1:0] tile;
        logic              load;
        logic [SLOT_W-1:0] slot;
        logic              status;
        logic [SLOT_W-1:0] active;
    } slot_result_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [ICON_W-1:0] icon;
        bit                drain;
        bit                hold;
        int                phase;
    } icon_req_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    icon_req_t    pending_q[$];
    slot_result_t expected_q[$];

    // model state
    bit [REF_W-1:0]  icon_refs [ICON_N];
    bit [SLOT_W-1:0] icon_slot_of [ICON_N];
    bit              slot_taken [SLOT_N];

    int          errors = 0;
    int          queued = 0;
    int          phase_sel = 0;
    bit          mark_next = 0;
    int          cur_phase = 0;
    logic        in_acc;
    int unsigned quiet_cycles;
    bit [7:0]    stall_tag = '0;
    bit [7:0]    stall_seen = '0;
    int unsigned hold_left = 0;

    refcounted_icon_slot_allocator #(
        .ICON_COUNT(ICON_N),
        .SLOT_COUNT(SLOT_N)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic slot_result_t allocate_slot(input logic [CMD_W-1:0] cmd,
                                                   input logic [ICON_W-1:0] icon);
        slot_result_t r;
        bit           found;
        int           i;
        r = '0;
        found = 1'b0;
        case (cmd)
            CMD_GET:
            begin
                if (icon >= ICON_N)
                begin
                    r.tile   = TILE_BASE;
                    r.status = 1'b1;
                end
                else
                begin
                    if (icon_refs[icon] != REF_MAX)
                        icon_refs[icon] = icon_refs[icon] + 1'b1;
                    if (icon_slot_of[icon] == 0)
                    begin
                        for (i = 0; i < SLOT_N && !found; i++)
                        begin
                            if (!slot_taken[i])
                            begin
                                slot_taken[i] = 1'b1;
                                icon_slot_of[icon] = SLOT_W'(i + 1);
                                r.load = 1'b1;
                                found = 1'b1;
                            end
                        end
                    end
                    if (icon_slot_of[icon] != 0)
                    begin
                        r.slot = icon_slot_of[icon];
                        r.tile = TILE_BASE - {2'b00, r.slot, 2'b00};
                    end
                    else
                    begin
                        r.tile   = TILE_BASE;
                        r.status = 1'b1;
                    end
                end
            end
            CMD_CLEAR_ONE:
            begin
                if (icon < ICON_N && icon_slot_of[icon] != 0)
                begin
                    slot_taken[icon_slot_of[icon] - 1] = 1'b0;
                    icon_slot_of[icon] = '0;
                end
            end
            CMD_CLEAR_ALL:
            begin
                foreach (icon_refs[k])
                begin
                    icon_refs[k] = '0;
                    icon_slot_of[k] = '0;
                end
                foreach (slot_taken[k])
                    slot_taken[k] = 1'b0;
            end
            default:
            begin
                foreach (slot_taken[k])
                    if (slot_taken[k])
                        r.active = r.active + 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic int idle_pct(input int phase, input bit rx_side);
        if (phase == 0)
            return rx_side ? 76 : 28;
        if (phase == 1)
            return rx_side ? 28 : 76;
        return 0;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic add_req(input logic [CMD_W-1:0] cmd, input logic [ICON_W-1:0] icon);
        icon_req_t it;
        it.cmd   = cmd;
        it.icon  = icon;
        it.drain = mark_next || ($urandom_range(99) == 0);
        it.hold  = mark_next || ($urandom_range(399) == 0);
        it.phase = phase_sel;
        mark_next = 1'b0;
        pending_q.push_back(it);
        queued++;
    endtask

    function automatic logic [CMD_W-1:0] pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return CMD_GET;
        if (r < 75)
            return CMD_CLEAR_ONE;
        if (r < 95)
            return CMD_COUNT;
        return CMD_CLEAR_ALL;
    endfunction

    function automatic logic [ICON_W-1:0] pick_icon();
        if ($urandom_range(99) < 70)
            return ICON_W'($urandom_range(39));
        return ICON_W'($urandom_range(255));
    endfunction

    // sender: one transaction offered at a time, held until accepted
    always @(negedge clk)
    begin : drive
        logic            nxt_valid;
        logic [IN_W-1:0] nxt_data;
        icon_req_t       head;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        if (s_tvalid && in_acc)
            nxt_valid = 1'b0;
        if (rst_n && !nxt_valid && pending_q.size() != 0)
        begin
            head = pending_q[0];
            if (!(head.drain && expected_q.size() != 0) &&
                $urandom_range(99) >= idle_pct(head.phase, 1'b0))
            begin
                head = pending_q.pop_front();
                nxt_valid = 1'b1;
                nxt_data  = {6'b0, head.icon, head.cmd};
                cur_phase <= head.phase;
                if (head.hold)
                    stall_tag <= stall_tag + 1'b1;
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
    end

    // receiver: random backpressure plus long hold-offs on request
    always @(negedge clk)
    begin
        if (stall_tag != stall_seen)
        begin
            stall_seen <= stall_tag;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= rst_n && ($urandom_range(99) >= idle_pct(cur_phase, 1'b1));
    end

    always @(posedge clk)
    begin : monitor
        slot_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transaction with nothing expected: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("tile_address", int'(want.tile), int'(m_tdata[9:0]));
                    check_field("load_needed", int'(want.load), int'(m_tdata[10]));
                    check_field("slot_number", int'(want.slot), int'(m_tdata[16:11]));
                    check_field("status", int'(want.status), int'(m_tdata[17]));
                    check_field("active_count", int'(want.active), int'(m_tdata[23:18]));
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(allocate_slot(s_tdata[1:0], s_tdata[9:2]));
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_acc       <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            in_acc <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("refcounted_icon_slot_allocator_tb failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int                dir_items;
        int                k;
        int                last_phase;
        bit                sat_done;
        logic [ICON_W-1:0] ic;
        logic [ICON_W-1:0] held_q[$];

        sat_done = 1'b0;

        // directed: edges of icon range, every command, hit/miss/ignored clears
        add_req(CMD_COUNT, 8'd0);
        add_req(CMD_GET, 8'd0);
        add_req(CMD_GET, 8'd0);
        add_req(CMD_GET, 8'd223);
        add_req(CMD_GET, 8'd224);
        add_req(CMD_GET, 8'd255);
        add_req(CMD_COUNT, 8'd255);
        add_req(CMD_CLEAR_ONE, 8'd0);
        add_req(CMD_CLEAR_ONE, 8'd0);
        add_req(CMD_CLEAR_ONE, 8'd255);
        add_req(CMD_CLEAR_ONE, 8'd224);
        add_req(CMD_GET, 8'd170);
        add_req(CMD_GET, 8'd85);
        add_req(CMD_GET, 8'd0);
        add_req(CMD_COUNT, 8'd170);
        add_req(CMD_CLEAR_ALL, 8'd85);
        add_req(CMD_COUNT, 8'd0);
        add_req(CMD_GET, 8'd223);
        add_req(CMD_CLEAR_ALL, 8'd255);
        dir_items  = queued;
        last_phase = 0;

        while (queued < dir_items + RAND_ITEMS)
        begin
            phase_sel = (queued - dir_items) * 3 / RAND_ITEMS;
            if (phase_sel != last_phase)
            begin
                mark_next  = 1'b1;
                last_phase = phase_sel;
            end
            else if (queued == dir_items + 40)
                mark_next = 1'b1;

            if (!sat_done && phase_sel == 2)
            begin
                // reference count saturation, then reallocation of the same icon
                add_req(CMD_CLEAR_ONE, 8'd7);
                repeat (260)
                    add_req(CMD_GET, 8'd7);
                add_req(CMD_CLEAR_ONE, 8'd7);
                add_req(CMD_GET, 8'd7);
                add_req(CMD_COUNT, 8'd7);
                sat_done = 1'b1;
            end
            else if ($urandom_range(99) < 15)
            begin
                // fill toward or past capacity, punch holes, refill lowest free slots
                add_req(CMD_CLEAR_ALL, ICON_W'($urandom));
                held_q.delete();
                k = $urandom_range(30, 40);
                repeat (k)
                begin
                    ic = ICON_W'($urandom_range(0, ICON_N - 1));
                    held_q.push_back(ic);
                    add_req(CMD_GET, ic);
                end
                add_req(CMD_COUNT, ICON_W'($urandom));
                repeat (4)
                begin
                    add_req(CMD_CLEAR_ONE, held_q[$urandom_range(held_q.size() - 1)]);
                    add_req(CMD_GET, ICON_W'($urandom_range(0, 255)));
                end
                add_req(CMD_GET, held_q[$urandom_range(held_q.size() - 1)]);
                add_req(CMD_COUNT, ICON_W'($urandom));
            end
            else
            begin
                repeat (8)
                    add_req(pick_cmd(), pick_icon());
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_q.size() == 0 && !s_tvalid && expected_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("refcounted_icon_slot_allocator_tb passed");
        else
            $display("refcounted_icon_slot_allocator_tb failed");
        $finish;
    end

endmodule

>>> files.f
hdl/rcisa_pkg.sv
hdl/rcisa_ram.sv
hdl/rcisa_ctrl.sv
hdl/rcisa_dp.sv
hdl/refcounted_icon_slot_allocator.sv
test/refcounted_icon_slot_allocator_tb.sv
